// File: hw/rtl/gmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gmc_pkg;

    // Genotype character codes
    localparam logic [7:0] CODE_MISSING = 8'h58;  // 'X'
    localparam logic [7:0] CODE_HET     = 8'h31;  // '1'

    // Fixed field widths
    localparam int CODE_WIDTH  = 8;
    localparam int FIELD_WIDTH = 16;
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;

    // Register indexes, taken from paddr[2]
    typedef enum logic {
        REG_MISMATCH_LIMIT  = 1'b0,
        REG_HOMOZYGOUS_ONLY = 1'b1
    } reg_index_t;

    localparam logic [FIELD_WIDTH-1:0] LIMIT_RESET = 16'hFFFF;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] mismatch_limit;
        logic                   homozygous_only;
    } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/gmc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module gmc_cfg_regs (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [gmc_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  wire logic [gmc_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic      [gmc_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                      pready,
    output gmc_pkg::cfg_t                             cfg
);

    gmc_pkg::cfg_t      cfg_reg;
    gmc_pkg::reg_index_t reg_sel;
    logic               wr_en;

    // Decode the word address and the write strobe
    assign reg_sel = gmc_pkg::reg_index_t'(paddr[2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // Hold the registers, update on a completed write request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mismatch_limit  <= gmc_pkg::LIMIT_RESET;
            cfg_reg.homozygous_only <= 1'b0;
        end else if (wr_en) begin
            case (reg_sel)
                gmc_pkg::REG_MISMATCH_LIMIT: begin
                    cfg_reg.mismatch_limit <= pwdata[gmc_pkg::FIELD_WIDTH-1:0];
                end
                gmc_pkg::REG_HOMOZYGOUS_ONLY: begin
                    cfg_reg.homozygous_only <= pwdata[0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        case (reg_sel)
            gmc_pkg::REG_MISMATCH_LIMIT: begin
                prdata = gmc_pkg::APB_DATA_WIDTH'(cfg_reg.mismatch_limit);
            end
            gmc_pkg::REG_HOMOZYGOUS_ONLY: begin
                prdata = gmc_pkg::APB_DATA_WIDTH'(cfg_reg.homozygous_only);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hw/rtl/gmc_count_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module gmc_count_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  gmc_pkg::cfg_t                          cfg,
    input  wire logic [gmc_pkg::CODE_WIDTH-1:0]    first_code,
    input  wire logic [gmc_pkg::CODE_WIDTH-1:0]    second_code,
    input  wire logic [gmc_pkg::FIELD_WIDTH-1:0]   seed_mismatches,
    input  wire logic                              first_of_string,
    input  wire logic [COUNT_WIDTH-1:0]            scan_q,
    input  wire logic [COUNT_WIDTH-1:0]            usable_q,
    input  wire logic [COUNT_WIDTH-1:0]            mism_q,
    input  wire logic                              stopped_q,
    output logic      [COUNT_WIDTH-1:0]            scan_d,
    output logic      [COUNT_WIDTH-1:0]            usable_d,
    output logic      [COUNT_WIDTH-1:0]            mism_d,
    output logic                                   stopped_d
);

    // Compare width covers both the counts and the 16-bit fields
    localparam int CmpWidth = (COUNT_WIDTH > gmc_pkg::FIELD_WIDTH) ?
                              COUNT_WIDTH : gmc_pkg::FIELD_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    logic [CmpWidth-1:0]    seed_ext;
    logic [CmpWidth-1:0]    max_ext;
    logic [CmpWidth-1:0]    limit_ext;
    logic [CmpWidth-1:0]    mism_ext;
    logic [COUNT_WIDTH-1:0] scan_base;
    logic [COUNT_WIDTH-1:0] usable_base;
    logic [COUNT_WIDTH-1:0] mism_base;
    logic                   stopped_base;
    logic [COUNT_WIDTH-1:0] scan_inc;
    logic [COUNT_WIDTH-1:0] usable_inc;
    logic [COUNT_WIDTH-1:0] mism_inc;
    logic                   first_ok;
    logic                   second_ok;
    logic                   pair_usable;
    logic                   halt;

    // Widen the seed, the count maximum and the limit so the seed can be clamped to the count range
    assign seed_ext  = CmpWidth'(seed_mismatches);
    assign max_ext   = CmpWidth'(CountMax);
    assign limit_ext = CmpWidth'(cfg.mismatch_limit);

    // Start a new string or carry on from the held counts
    always_comb begin
        if (first_of_string) begin
            scan_base    = '0;
            usable_base  = '0;
            mism_base    = (seed_ext > max_ext) ? CountMax : seed_ext[COUNT_WIDTH-1:0];
            stopped_base = 1'b0;
        end else begin
            scan_base    = scan_q;
            usable_base  = usable_q;
            mism_base    = mism_q;
            stopped_base = stopped_q;
        end
    end

    // Saturating increments
    assign scan_inc   = (scan_base == CountMax)   ? scan_base   : scan_base + 1'b1;
    assign usable_inc = (usable_base == CountMax) ? usable_base : usable_base + 1'b1;
    assign mism_inc   = (mism_base == CountMax)   ? mism_base   : mism_base + 1'b1;

    // Drop missing codes, and heterozygous codes in homozygous mode
    assign first_ok  = (first_code != gmc_pkg::CODE_MISSING) &&
                       !(cfg.homozygous_only && (first_code == gmc_pkg::CODE_HET));
    assign second_ok = (second_code != gmc_pkg::CODE_MISSING) &&
                       !(cfg.homozygous_only && (second_code == gmc_pkg::CODE_HET));
    assign pair_usable = first_ok && second_ok;

    // Count the pair and test the limit
    always_comb begin
        usable_d  = usable_base;
        mism_d    = mism_base;
        scan_d    = scan_base;
        stopped_d = stopped_base;
        halt      = 1'b0;
        mism_ext  = CmpWidth'(mism_base);
        if (!stopped_base) begin
            if (pair_usable) begin
                usable_d = usable_inc;
                if (first_code != second_code) begin
                    mism_d = mism_inc;
                end
                mism_ext = CmpWidth'(mism_d);
                halt     = (mism_ext >= limit_ext);
            end
            if (halt) begin
                stopped_d = 1'b1;
            end else begin
                scan_d = scan_inc;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bounded_genotype_mismatch_count_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    | Dir    | Handshake              | Payload
// -----------+--------+------------------------+--------------------------------------------
// input pair | in     | s_valid, s_ready       | s_first_code .. s_last_of_string, 5 fields
// result     | out    | m_valid, m_ready       | m_scanned_count .. m_limit_hit, 4 fields
// config     | in/out | psel, penable, pready  | pwrite, paddr, pwdata, prdata
//
// One pair per cycle unless a last pair meets a full result slot: an input register feeds
// the count unit, which updates the string counts and the result register.
// A result is loaded into the result register when its last pair leaves the input register.
// Synchronous active-low reset clears the counts, the valid flags and the
// configuration registers.
// A stalled result holds the pipeline only when a last pair has to enter it.

module bounded_genotype_mismatch_count_top #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input pairs
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [7:0]                           s_first_code,
    input  wire logic [7:0]                           s_second_code,
    input  wire logic [15:0]                          s_seed_mismatches,
    input  wire logic                                 s_first_of_string,
    input  wire logic                                 s_last_of_string,
    // results
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic      [15:0]                          m_scanned_count,
    output logic      [15:0]                          m_usable_count,
    output logic      [15:0]                          m_mismatch_total,
    output logic                                      m_limit_hit,
    // configuration
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [gmc_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  wire logic [gmc_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic      [gmc_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                      pready
);

    gmc_pkg::cfg_t          cfg;

    logic                   in_valid_reg;
    logic [7:0]             first_code_reg;
    logic [7:0]             second_code_reg;
    logic [15:0]            seed_reg;
    logic                   first_reg;
    logic                   last_reg;

    logic [COUNT_WIDTH-1:0] scan_reg;
    logic [COUNT_WIDTH-1:0] usable_reg;
    logic [COUNT_WIDTH-1:0] mism_reg;
    logic                   stopped_reg;
    logic [COUNT_WIDTH-1:0] scan_next;
    logic [COUNT_WIDTH-1:0] usable_next;
    logic [COUNT_WIDTH-1:0] mism_next;
    logic                   stopped_next;

    logic                   out_valid_reg;
    logic [15:0]            scanned_reg;
    logic [15:0]            usable_out_reg;
    logic [15:0]            total_reg;
    logic                   limit_hit_reg;

    logic                   advance;
    logic                   take_in;

    gmc_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // A held pair moves on unless it is a last pair and the result slot is full
    assign advance = in_valid_reg && (!last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take_in = s_valid && s_ready;

    // Input register: control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Input register: payload
    always_ff @(posedge aclk) begin
        if (take_in) begin
            first_code_reg  <= s_first_code;
            second_code_reg <= s_second_code;
            seed_reg        <= s_seed_mismatches;
            first_reg       <= s_first_of_string;
            last_reg        <= s_last_of_string;
        end
    end

    gmc_count_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count_unit (
        .cfg             (cfg),
        .first_code      (first_code_reg),
        .second_code     (second_code_reg),
        .seed_mismatches (seed_reg),
        .first_of_string (first_reg),
        .scan_q          (scan_reg),
        .usable_q        (usable_reg),
        .mism_q          (mism_reg),
        .stopped_q       (stopped_reg),
        .scan_d          (scan_next),
        .usable_d        (usable_next),
        .mism_d          (mism_next),
        .stopped_d       (stopped_next)
    );

    // String counts advance with each pair leaving the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg    <= '0;
            usable_reg  <= '0;
            mism_reg    <= '0;
            stopped_reg <= 1'b0;
        end else if (advance) begin
            scan_reg    <= scan_next;
            usable_reg  <= usable_next;
            mism_reg    <= mism_next;
            stopped_reg <= stopped_next;
        end
    end

    // Result register: control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge aclk) begin
        if (advance && last_reg) begin
            scanned_reg    <= 16'(scan_next);
            usable_out_reg <= 16'(usable_next);
            total_reg      <= 16'(mism_next);
            limit_hit_reg  <= stopped_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_scanned_count  = scanned_reg;
    assign m_usable_count   = usable_out_reg;
    assign m_mismatch_total = total_reg;
    assign m_limit_hit      = limit_hit_reg;

endmodule

`default_nettype wire

// File: hw/rtl/gmc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module gmc_checker (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_ready,
    input  wire logic                                 m_valid,
    input  wire logic                                 m_ready,
    input  wire logic [15:0]                          m_scanned_count,
    input  wire logic [15:0]                          m_usable_count,
    input  wire logic [15:0]                          m_mismatch_total,
    input  wire logic                                 m_limit_hit,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [gmc_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  wire logic [gmc_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    input  wire logic [gmc_pkg::APB_DATA_WIDTH-1:0]   prdata,
    input  wire logic                                 pready
);

    // Hold a stalled result unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scanned_count) &&
        $stable(m_usable_count) && $stable(m_mismatch_total) && $stable(m_limit_hit))
    else $error("stalled result changed");

    // Refuse input only while a result waits to be taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
    else $error("input stalled without output back-pressure");

    // Never insert wait states on the configuration port
    assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
    else $error("pready dropped");

    // Read back a limit just written
    assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && !paddr[2]) ##1 (psel && !pwrite && !paddr[2])
        |-> prdata[15:0] == $past(pwdata[15:0]))
    else $error("limit read-back mismatch");

endmodule

bind bounded_genotype_mismatch_count_top gmc_checker u_gmc_checker (.*);

`default_nettype wire
